// ===== src/qvr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_pkg
// Widths and stage payload types for the quaternion vector rotator.
// ----------------------------------------------------------------------------
package qvr_pkg;

  localparam int QUAT_FRAC_BITS = 14;
  localparam int VEC_WIDTH      = 24;

  localparam int QW    = 16;                  // quaternion component width
  localparam int PV_W  = QW + VEC_WIDTH;      // q * v product
  localparam int T_W   = PV_W + 2;            // sum of three products
  localparam int PU_W  = T_W + QW;            // t * q product
  localparam int SHIFT = 2 * QUAT_FRAC_BITS;
  localparam int U_W   = (PU_W + 2 > SHIFT + 2) ? PU_W + 2 : SHIFT + 2;

  localparam logic signed [U_W-1:0] RND_HALF = {{(U_W-1){1'b0}}, 1'b1} << (SHIFT - 1);
  localparam logic signed [U_W-1:0] SAT_HI =
    {{(U_W-VEC_WIDTH+1){1'b0}}, {(VEC_WIDTH-1){1'b1}}};
  localparam logic signed [U_W-1:0] SAT_LO =
    {{(U_W-VEC_WIDTH+1){1'b1}}, {(VEC_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic signed [QW-1:0]   qx;
    logic signed [QW-1:0]   qy;
    logic signed [QW-1:0]   qz;
    logic signed [QW-1:0]   qw;
    logic signed [PV_W-1:0] p_wx;
    logic signed [PV_W-1:0] p_yz;
    logic signed [PV_W-1:0] p_zy;
    logic signed [PV_W-1:0] p_wy;
    logic signed [PV_W-1:0] p_zx;
    logic signed [PV_W-1:0] p_xz;
    logic signed [PV_W-1:0] p_wz;
    logic signed [PV_W-1:0] p_xy;
    logic signed [PV_W-1:0] p_yx;
    logic signed [PV_W-1:0] p_xx;
    logic signed [PV_W-1:0] p_yy;
    logic signed [PV_W-1:0] p_zz;
  } vprod_t;

  typedef struct packed {
    logic signed [QW-1:0]  qx;
    logic signed [QW-1:0]  qy;
    logic signed [QW-1:0]  qz;
    logic signed [QW-1:0]  qw;
    logic signed [T_W-1:0] tx;
    logic signed [T_W-1:0] ty;
    logic signed [T_W-1:0] tz;
    logic signed [T_W-1:0] tw;
  } tvec_t;

  typedef struct packed {
    logic signed [PU_W-1:0] x0;
    logic signed [PU_W-1:0] x1;
    logic signed [PU_W-1:0] x2;
    logic signed [PU_W-1:0] x3;
    logic signed [PU_W-1:0] y0;
    logic signed [PU_W-1:0] y1;
    logic signed [PU_W-1:0] y2;
    logic signed [PU_W-1:0] y3;
    logic signed [PU_W-1:0] z0;
    logic signed [PU_W-1:0] z1;
    logic signed [PU_W-1:0] z2;
    logic signed [PU_W-1:0] z3;
  } uprod_t;

  typedef struct packed {
    logic signed [U_W-1:0] rx;
    logic signed [U_W-1:0] ry;
    logic signed [U_W-1:0] rz;
  } rvec_t;

endpackage

// ===== src/qvr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_in_if / qvr_out_if
// Valid/ready channels for quaternion-vector beats and rotated results.
// ----------------------------------------------------------------------------
interface qvr_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [qvr_pkg::QW-1:0]         quat_x;
  logic signed [qvr_pkg::QW-1:0]         quat_y;
  logic signed [qvr_pkg::QW-1:0]         quat_z;
  logic signed [qvr_pkg::QW-1:0]         quat_w;
  logic signed [qvr_pkg::VEC_WIDTH-1:0]  vec_x;
  logic signed [qvr_pkg::VEC_WIDTH-1:0]  vec_y;
  logic signed [qvr_pkg::VEC_WIDTH-1:0]  vec_z;

  modport source (output valid, quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z,
                  input ready);
  modport sink (input valid, quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z,
                output ready);
endinterface

interface qvr_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [qvr_pkg::VEC_WIDTH-1:0]  rot_x;
  logic signed [qvr_pkg::VEC_WIDTH-1:0]  rot_y;
  logic signed [qvr_pkg::VEC_WIDTH-1:0]  rot_z;
  logic                                  clipped;

  modport source (output valid, rot_x, rot_y, rot_z, clipped, input ready);
  modport sink (input valid, rot_x, rot_y, rot_z, clipped, output ready);
endinterface

// ===== src/qvr_tmult.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_tmult
// First half: q*v products, then t = w*v + qv x v and tw = -qv.v.
// ----------------------------------------------------------------------------
module qvr_tmult (
  input  logic           clk,
  input  logic           rst_n,
  qvr_in_if.sink         in_chan,
  output qvr_pkg::tvec_t t_o,
  output logic           t_valid_o,
  input  logic           t_ready_i
);

  localparam int PV_W = qvr_pkg::PV_W;
  localparam int T_W  = qvr_pkg::T_W;

  qvr_pkg::vprod_t pa_r, pa_nxt;
  qvr_pkg::tvec_t  tb_r, tb_nxt;
  logic            va_r, vb_r;
  logic            ready_a, ready_b;

  assign ready_b       = !vb_r || t_ready_i;
  assign ready_a       = !va_r || ready_b;
  assign in_chan.ready = ready_a;

  always_comb begin
    pa_nxt.qx   = in_chan.quat_x;
    pa_nxt.qy   = in_chan.quat_y;
    pa_nxt.qz   = in_chan.quat_z;
    pa_nxt.qw   = in_chan.quat_w;
    pa_nxt.p_wx = PV_W'(in_chan.quat_w) * PV_W'(in_chan.vec_x);
    pa_nxt.p_yz = PV_W'(in_chan.quat_y) * PV_W'(in_chan.vec_z);
    pa_nxt.p_zy = PV_W'(in_chan.quat_z) * PV_W'(in_chan.vec_y);
    pa_nxt.p_wy = PV_W'(in_chan.quat_w) * PV_W'(in_chan.vec_y);
    pa_nxt.p_zx = PV_W'(in_chan.quat_z) * PV_W'(in_chan.vec_x);
    pa_nxt.p_xz = PV_W'(in_chan.quat_x) * PV_W'(in_chan.vec_z);
    pa_nxt.p_wz = PV_W'(in_chan.quat_w) * PV_W'(in_chan.vec_z);
    pa_nxt.p_xy = PV_W'(in_chan.quat_x) * PV_W'(in_chan.vec_y);
    pa_nxt.p_yx = PV_W'(in_chan.quat_y) * PV_W'(in_chan.vec_x);
    pa_nxt.p_xx = PV_W'(in_chan.quat_x) * PV_W'(in_chan.vec_x);
    pa_nxt.p_yy = PV_W'(in_chan.quat_y) * PV_W'(in_chan.vec_y);
    pa_nxt.p_zz = PV_W'(in_chan.quat_z) * PV_W'(in_chan.vec_z);
  end

  always_comb begin
    tb_nxt.qx = pa_r.qx;
    tb_nxt.qy = pa_r.qy;
    tb_nxt.qz = pa_r.qz;
    tb_nxt.qw = pa_r.qw;
    tb_nxt.tx = T_W'(pa_r.p_wx) + T_W'(pa_r.p_yz) - T_W'(pa_r.p_zy);
    tb_nxt.ty = T_W'(pa_r.p_wy) + T_W'(pa_r.p_zx) - T_W'(pa_r.p_xz);
    tb_nxt.tz = T_W'(pa_r.p_wz) + T_W'(pa_r.p_xy) - T_W'(pa_r.p_yx);
    tb_nxt.tw = -(T_W'(pa_r.p_xx) + T_W'(pa_r.p_yy) + T_W'(pa_r.p_zz));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (ready_a) va_r <= in_chan.valid;
      if (ready_b) vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a) pa_r <= pa_nxt;
    if (ready_b) tb_r <= tb_nxt;
  end

  assign t_o       = tb_r;
  assign t_valid_o = vb_r;

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> va_r)
    else $error("accepted beat did not enter product stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    va_r && !ready_b |=> va_r && $stable(pa_r))
    else $error("product stage changed while stalled");

endmodule

// ===== src/qvr_umult.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_umult
// Second half: t*q products, then signed sum, round half up and scale down.
// ----------------------------------------------------------------------------
module qvr_umult (
  input  logic           clk,
  input  logic           rst_n,
  input  qvr_pkg::tvec_t t_i,
  input  logic           t_valid_i,
  output logic           t_ready_o,
  output qvr_pkg::rvec_t r_o,
  output logic           r_valid_o,
  input  logic           r_ready_i
);

  localparam int PU_W = qvr_pkg::PU_W;
  localparam int U_W  = qvr_pkg::U_W;

  qvr_pkg::uprod_t pc_r, pc_nxt;
  qvr_pkg::rvec_t  rd_r, rd_nxt;
  logic            vc_r, vd_r;
  logic            ready_c, ready_d;

  assign ready_d   = !vd_r || r_ready_i;
  assign ready_c   = !vc_r || ready_d;
  assign t_ready_o = ready_c;

  // u = -tw*qv + w*t - t x qv
  always_comb begin
    pc_nxt.x0 = PU_W'(t_i.tw) * PU_W'(t_i.qx);
    pc_nxt.x1 = PU_W'(t_i.tx) * PU_W'(t_i.qw);
    pc_nxt.x2 = PU_W'(t_i.ty) * PU_W'(t_i.qz);
    pc_nxt.x3 = PU_W'(t_i.tz) * PU_W'(t_i.qy);
    pc_nxt.y0 = PU_W'(t_i.tw) * PU_W'(t_i.qy);
    pc_nxt.y1 = PU_W'(t_i.ty) * PU_W'(t_i.qw);
    pc_nxt.y2 = PU_W'(t_i.tz) * PU_W'(t_i.qx);
    pc_nxt.y3 = PU_W'(t_i.tx) * PU_W'(t_i.qz);
    pc_nxt.z0 = PU_W'(t_i.tw) * PU_W'(t_i.qz);
    pc_nxt.z1 = PU_W'(t_i.tz) * PU_W'(t_i.qw);
    pc_nxt.z2 = PU_W'(t_i.tx) * PU_W'(t_i.qy);
    pc_nxt.z3 = PU_W'(t_i.ty) * PU_W'(t_i.qx);
  end

  always_comb begin
    rd_nxt.rx = (U_W'(pc_r.x1) - U_W'(pc_r.x0) - U_W'(pc_r.x2) + U_W'(pc_r.x3)
                 + qvr_pkg::RND_HALF) >>> qvr_pkg::SHIFT;
    rd_nxt.ry = (U_W'(pc_r.y1) - U_W'(pc_r.y0) - U_W'(pc_r.y2) + U_W'(pc_r.y3)
                 + qvr_pkg::RND_HALF) >>> qvr_pkg::SHIFT;
    rd_nxt.rz = (U_W'(pc_r.z1) - U_W'(pc_r.z0) - U_W'(pc_r.z2) + U_W'(pc_r.z3)
                 + qvr_pkg::RND_HALF) >>> qvr_pkg::SHIFT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      if (ready_c) vc_r <= t_valid_i;
      if (ready_d) vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_c) pc_r <= pc_nxt;
    if (ready_d) rd_r <= rd_nxt;
  end

  assign r_o       = rd_r;
  assign r_valid_o = vd_r;

endmodule

// ===== src/qvr_sat.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_sat
// Saturates each component to the vector range and drives the output register.
// ----------------------------------------------------------------------------
module qvr_sat (
  input  logic           clk,
  input  logic           rst_n,
  input  qvr_pkg::rvec_t r_i,
  input  logic           r_valid_i,
  output logic           r_ready_o,
  qvr_out_if.source      out_chan
);

  localparam int VW = qvr_pkg::VEC_WIDTH;

  logic signed [VW-1:0] rx_r, ry_r, rz_r, rx_nxt, ry_nxt, rz_nxt;
  logic                 clip_r, clip_nxt;
  logic                 v_r;
  logic                 cx, cy, cz;
  logic                 ready_e;

  assign ready_e   = !v_r || out_chan.ready;
  assign r_ready_o = ready_e;

  always_comb begin
    cx = 1'b1;
    cy = 1'b1;
    cz = 1'b1;
    if (r_i.rx > qvr_pkg::SAT_HI) rx_nxt = qvr_pkg::SAT_HI[VW-1:0];
    else if (r_i.rx < qvr_pkg::SAT_LO) rx_nxt = qvr_pkg::SAT_LO[VW-1:0];
    else begin
      rx_nxt = r_i.rx[VW-1:0];
      cx     = 1'b0;
    end
    if (r_i.ry > qvr_pkg::SAT_HI) ry_nxt = qvr_pkg::SAT_HI[VW-1:0];
    else if (r_i.ry < qvr_pkg::SAT_LO) ry_nxt = qvr_pkg::SAT_LO[VW-1:0];
    else begin
      ry_nxt = r_i.ry[VW-1:0];
      cy     = 1'b0;
    end
    if (r_i.rz > qvr_pkg::SAT_HI) rz_nxt = qvr_pkg::SAT_HI[VW-1:0];
    else if (r_i.rz < qvr_pkg::SAT_LO) rz_nxt = qvr_pkg::SAT_LO[VW-1:0];
    else begin
      rz_nxt = r_i.rz[VW-1:0];
      cz     = 1'b0;
    end
    clip_nxt = cx || cy || cz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ready_e) begin
      v_r <= r_valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_e) begin
      rx_r   <= rx_nxt;
      ry_r   <= ry_nxt;
      rz_r   <= rz_nxt;
      clip_r <= clip_nxt;
    end
  end

  assign out_chan.valid   = v_r;
  assign out_chan.rot_x   = rx_r;
  assign out_chan.rot_y   = ry_r;
  assign out_chan.rot_z   = rz_r;
  assign out_chan.clipped = clip_r;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !v_r)
    else $error("output valid after reset");

  a_clip_at_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v_r && clip_r |->
      (rx_r == qvr_pkg::SAT_HI[VW-1:0]) || (rx_r == qvr_pkg::SAT_LO[VW-1:0]) ||
      (ry_r == qvr_pkg::SAT_HI[VW-1:0]) || (ry_r == qvr_pkg::SAT_LO[VW-1:0]) ||
      (rz_r == qvr_pkg::SAT_HI[VW-1:0]) || (rz_r == qvr_pkg::SAT_LO[VW-1:0]))
    else $error("clipped flagged with no component at a bound");

endmodule

// ===== src/quaternion_vector_rotate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_vector_rotate
// Rotates a vector by a Q1.14 quaternion, q*(v,0)*conj(q), rounded and
// saturated.
// ----------------------------------------------------------------------------
// Takes one beat per clock while the output is not stalled and returns
// one result beat per input beat, in order. The pipeline is product
// stage, t sum, product stage, sum and round, saturate and output
// register; the two banks of twelve multipliers set the stage depth. A
// stall at the output backs up stage by stage, and empty stages keep
// taking beats. The quaternion is not normalized, so a non-unit q also
// scales the vector by |q|^2; clipped marks a result with any component
// saturated.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate (
  input  logic       clk,
  input  logic       rst_n,
  qvr_in_if.sink     in_chan,
  qvr_out_if.source  out_chan
);

  qvr_pkg::tvec_t t_beat;
  qvr_pkg::rvec_t r_beat;
  logic           t_valid, t_ready;
  logic           r_valid, r_ready;

  qvr_tmult u_tmult (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .t_o       (t_beat),
    .t_valid_o (t_valid),
    .t_ready_i (t_ready)
  );

  qvr_umult u_umult (
    .clk       (clk),
    .rst_n     (rst_n),
    .t_i       (t_beat),
    .t_valid_i (t_valid),
    .t_ready_o (t_ready),
    .r_o       (r_beat),
    .r_valid_o (r_valid),
    .r_ready_i (r_ready)
  );

  qvr_sat u_sat (
    .clk       (clk),
    .rst_n     (rst_n),
    .r_i       (r_beat),
    .r_valid_i (r_valid),
    .r_ready_o (r_ready),
    .out_chan  (out_chan)
  );

endmodule

// ===== tb/qvr_rotation_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_rotation_check
// Watches both channels of the rotator and checks every result beat.
// Each accepted input beat is rotated here with exact wide arithmetic,
// rounded half up and saturated. The expected vector is queued in order.
// Each accepted result beat is compared field by field with the oldest
// entry in the queue.
// ----------------------------------------------------------------------------
module qvr_rotation_check
  import qvr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  qvr_in_if    in_chan,
  qvr_out_if   out_chan,
  output int   n_fail,
  output int   n_pending,
  output int   n_results,
  output int   n_clip
);

  localparam int VW  = VEC_WIDTH;
  localparam int RSH = 2 * QUAT_FRAC_BITS;
  localparam logic signed [127:0] VMAX     = (128'sd1 <<< (VW - 1)) - 128'sd1;
  localparam logic signed [127:0] VMIN     = -VMAX - 128'sd1;
  localparam logic signed [127:0] HALF_LSB = 128'sd1 <<< (RSH - 1);

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [VW-1:0] z;
    logic                 clip;
  } rot_t;

  rot_t expected_rot[$];
  rot_t exp_now;
  int   fails   = 0;
  int   results = 0;
  int   clips   = 0;

  function automatic void round_sat(input logic signed [127:0] u,
                                    output logic signed [VW-1:0] r, output logic c);
    logic signed [127:0] s;
    s = (u + HALF_LSB) >>> RSH;
    c = 1'b1;
    if (s > VMAX) begin
      r = VMAX[VW-1:0];
    end else if (s < VMIN) begin
      r = VMIN[VW-1:0];
    end else begin
      r = s[VW-1:0];
      c = 1'b0;
    end
  endfunction

  function automatic rot_t rotate_vec(input logic signed [QW-1:0] qx, qy, qz, qw,
                                      input logic signed [VW-1:0] vx, vy, vz);
    logic signed [127:0] ax, ay, az, aw, bx, by, bz, tx, ty, tz, tw;
    logic signed [VW-1:0] rx, ry, rz;
    logic cx, cy, cz;
    rot_t r;
    ax = qx;
    ay = qy;
    az = qz;
    aw = qw;
    bx = vx;
    by = vy;
    bz = vz;
    // t = w*v + qv x v, tw = -(qv . v)
    tx = aw * bx + ay * bz - az * by;
    ty = aw * by + az * bx - ax * bz;
    tz = aw * bz + ax * by - ay * bx;
    tw = -(ax * bx + ay * by + az * bz);
    // u = tw*(-qv) + w*t + t x (-qv)
    round_sat(tx * aw - tw * ax - ty * az + tz * ay, rx, cx);
    round_sat(ty * aw - tw * ay - tz * ax + tx * az, ry, cy);
    round_sat(tz * aw - tw * az - tx * ay + ty * ax, rz, cz);
    r.x    = rx;
    r.y    = ry;
    r.z    = rz;
    r.clip = cx | cy | cz;
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [VW-1:0] want, got);
    if (got !== want) begin
      fails++;
      if (fails <= 40)
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready)
        expected_rot.push_back(rotate_vec(in_chan.quat_x, in_chan.quat_y, in_chan.quat_z,
                                          in_chan.quat_w, in_chan.vec_x, in_chan.vec_y,
                                          in_chan.vec_z));
      if (out_chan.valid && out_chan.ready) begin
        results++;
        if (expected_rot.size() == 0) begin
          fails++;
          if (fails <= 40)
            $display("%0t ns: result beat with none expected, actual (%0d, %0d, %0d) clip %0b",
                     $time, out_chan.rot_x, out_chan.rot_y, out_chan.rot_z, out_chan.clipped);
        end else begin
          exp_now = expected_rot.pop_front();
          check_field("rot_x", exp_now.x, out_chan.rot_x);
          check_field("rot_y", exp_now.y, out_chan.rot_y);
          check_field("rot_z", exp_now.z, out_chan.rot_z);
          check_field("clipped", {{(VW-1){1'b0}}, exp_now.clip},
                      {{(VW-1){1'b0}}, out_chan.clipped});
          if (exp_now.clip)
            clips++;
        end
      end
    end
    n_fail    <= fails;
    n_pending <= expected_rot.size();
    n_results <= results;
    n_clip    <= clips;
  end

endmodule

// ===== tb/tb_quaternion_vector_rotate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quaternion_vector_rotate
// Stimulus and verdict for the quaternion vector rotator.
// A directed set covers identity, axis turns, zero and extreme quaternions,
// saturation both ways and exact-half rounding. Random beats follow, a mix
// of near-unit rotations, full-range and small quaternions. Both channels
// idle in random bursts, and the output is held off once long enough to
// back up the pipeline. The result check runs in qvr_rotation_check.
// ----------------------------------------------------------------------------
module tb_quaternion_vector_rotate;
  import qvr_pkg::*;

  localparam int N_ITEMS        = 1900;
  localparam int QUIET_TAIL     = 200;
  localparam int HOLD_AT        = 700;
  localparam int HOLD_CYCLES    = 64;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic signed [QW-1:0]        Q_ONE  = 16'sd16384;
  localparam logic signed [QW-1:0]        Q_HALF = 16'sd8192;
  localparam logic signed [QW-1:0]        Q_C45  = 16'sd11585;
  localparam logic signed [QW-1:0]        Q_MAX  = 16'sh7fff;
  localparam logic signed [QW-1:0]        Q_MIN  = 16'sh8000;
  localparam logic signed [VEC_WIDTH-1:0] V_MAX  = 24'sh7fffff;
  localparam logic signed [VEC_WIDTH-1:0] V_MIN  = 24'sh800000;

  logic clk = 1'b0;
  logic rst_n;

  always #4 clk = ~clk;

  qvr_in_if  in_chan ();
  qvr_out_if out_chan ();

  int n_fail, n_pending, n_results, n_clip;
  int sent = 0;
  int n_directed = 0;
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int quiet = 0;
  bit press_on = 1'b0;
  bit held = 1'b0;
  bit tail = 1'b0;

  quaternion_vector_rotate i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  qvr_rotation_check i_rotation_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .n_fail    (n_fail),
    .n_pending (n_pending),
    .n_results (n_results),
    .n_clip    (n_clip)
  );

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 5;
      2:       return 20;
      default: return 45;
    endcase
  endfunction

  function automatic logic signed [QW-1:0] rand16();
    logic [31:0] r;
    r = $urandom;
    return r[QW-1:0];
  endfunction

  function automatic logic signed [VEC_WIDTH-1:0] rand24();
    logic [31:0] r;
    r = $urandom;
    return r[VEC_WIDTH-1:0];
  endfunction

  // Offer one beat and return at the edge where it is taken.
  task automatic offer_rotation(input logic signed [QW-1:0] qx, qy, qz, qw,
                                input logic signed [VEC_WIDTH-1:0] vx, vy, vz);
    if (sent % 128 == 0)
      in_idle_pct = pick_pct();
    tail = (sent >= N_ITEMS - QUIET_TAIL);
    if (!tail && !press_on && $urandom_range(1, 100) <= in_idle_pct) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_chan.valid  <= 1'b1;
    in_chan.quat_x <= qx;
    in_chan.quat_y <= qy;
    in_chan.quat_z <= qz;
    in_chan.quat_w <= qw;
    in_chan.vec_x  <= vx;
    in_chan.vec_y  <= vy;
    in_chan.vec_z  <= vz;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    sent++;
  endtask

  // Result side: random stalls, one long hold-off with the input still offered.
  initial begin
    int span;
    span = 0;
    out_chan.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (span == 0) begin
        out_idle_pct = pick_pct();
        span = 200;
      end
      span--;
      if (!held && sent >= HOLD_AT) begin
        held = 1'b1;
        press_on = 1'b1;
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        press_on = 1'b0;
      end else if (!tail && $urandom_range(1, 100) <= out_idle_pct) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("%0t ns: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("quaternion_vector_rotate regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int kind;
    real c[4];
    real nrm;
    logic signed [QW-1:0] q[4];
    logic signed [VEC_WIDTH-1:0] v[3];
    rst_n          <= 1'b0;
    in_chan.valid  <= 1'b0;
    in_chan.quat_x <= '0;
    in_chan.quat_y <= '0;
    in_chan.quat_z <= '0;
    in_chan.quat_w <= '0;
    in_chan.vec_x  <= '0;
    in_chan.vec_y  <= '0;
    in_chan.vec_z  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity, axis turns, zero quaternion
    offer_rotation(0, 0, 0, Q_ONE, 1, -1, 0);
    offer_rotation(0, 0, 0, Q_ONE, V_MAX, V_MIN, 0);
    offer_rotation(0, 0, 0, Q_ONE, V_MIN, V_MIN, V_MIN);
    offer_rotation(0, 0, 0, 0, V_MAX, V_MAX, V_MAX);
    offer_rotation(0, 0, Q_C45, Q_C45, 1000000, 0, 0);
    offer_rotation(Q_ONE, 0, 0, 0, 5, 7, -9);
    offer_rotation(0, Q_C45, 0, Q_C45, 0, 0, 4000000);
    // non-unit scaling and saturation both ways
    offer_rotation(0, 0, 0, Q_MAX, 1000, -1000, 3000);
    offer_rotation(0, 0, 0, Q_MIN, 2097151, -2097152, 2097152);
    offer_rotation(0, 0, 0, Q_MAX, V_MAX, 0, 0);
    offer_rotation(0, 0, 0, Q_MAX, V_MIN, 0, 0);
    offer_rotation(Q_MAX, Q_MAX, Q_MAX, Q_MAX, V_MAX, V_MAX, V_MAX);
    offer_rotation(Q_MIN, Q_MIN, Q_MIN, Q_MIN, V_MIN, V_MIN, V_MIN);
    offer_rotation(Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1, 2, 3);
    offer_rotation(Q_MAX, 0, 0, 0, V_MIN, V_MAX, -1);
    // exact halves and quarters after scaling by w^2 = 1/4
    offer_rotation(0, 0, 0, Q_HALF, 2, -2, 1);
    offer_rotation(0, 0, 0, Q_HALF, 3, -3, -1);
    offer_rotation(0, 0, 0, -Q_HALF, 6, -6, 0);
    offer_rotation(100, -200, 300, 16000, 12345, -67890, 424242);
    n_directed = sent;

    while (sent < N_ITEMS) begin
      kind = $urandom_range(0, 99);
      v[0] = rand24();
      v[1] = rand24();
      v[2] = rand24();
      if (kind < 45) begin
        for (int i = 0; i < 4; i++)
          c[i] = real'($urandom_range(0, 65534)) - 32767.0;
        nrm = $sqrt(c[0] * c[0] + c[1] * c[1] + c[2] * c[2] + c[3] * c[3]);
        for (int i = 0; i < 4; i++)
          q[i] = (nrm < 1.0) ? ((i == 3) ? Q_ONE : 16'sd0) : 16'($rtoi(c[i] * 16384.0 / nrm));
      end else if (kind < 70) begin
        for (int i = 0; i < 4; i++)
          q[i] = rand16();
      end else if (kind < 85) begin
        for (int i = 0; i < 4; i++)
          q[i] = 16'(int'($urandom_range(0, 8192)) - 4096);
      end else begin
        // scalar-only or single-axis quaternion on tiny vectors: rounding edges
        case ($urandom_range(0, 3))
          0:       q[3] = Q_HALF;
          1:       q[3] = -Q_HALF;
          2:       q[3] = Q_ONE;
          default: q[3] = rand16();
        endcase
        q[0] = 0;
        q[1] = 0;
        q[2] = 0;
        if ($urandom_range(0, 1))
          q[$urandom_range(0, 2)] = q[3];
        for (int i = 0; i < 3; i++)
          v[i] = 24'(int'($urandom_range(0, 64)) - 32);
      end
      offer_rotation(q[0], q[1], q[2], q[3], v[0], v[1], v[2]);
    end
    in_chan.valid <= 1'b0;

    @(posedge clk);
    wait (n_pending == 0);
    repeat (20) @(posedge clk);

    $display("Rotated %0d vectors (%0d directed), checked %0d results, %0d saturated.",
             sent, n_directed, n_results, n_clip);
    $display("Result side held off once for %0d cycles with input still offered.",
             HOLD_CYCLES);
    if (n_fail == 0 && n_pending == 0) begin
      $display("quaternion_vector_rotate regression: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", n_fail, n_pending);
      $display("quaternion_vector_rotate regression: fail");
    end
    $finish;
  end

endmodule
